FILE: hw/rtl/rle1_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers of the type 1 run-length encoder.
package rle1_pkg;

  localparam int LiteralMax = 128;   // longest literal group, default
  localparam int RunMax     = 129;   // longest run
  localparam int RunBase    = 126;   // run header is RunBase plus run length
  localparam int CountW     = 8;     // width of run and literal counters
  localparam int WordBytes  = 4;     // bytes packed into one result word

  typedef enum logic [1:0] {
    FM_EMPTY = 2'd0,
    FM_ONE   = 2'd1,
    FM_RUN   = 2'd2,
    FM_LIT   = 2'd3
  } frame_mode_e;

  typedef enum logic [1:0] {
    EP_IDLE = 2'd0,
    EP_HDR  = 2'd1,
    EP_BODY = 2'd2,
    EP_TAIL = 2'd3
  } emit_phase_e;

  // One compressed byte on its way to the word packer.
  typedef struct packed {
    logic [7:0] data;
    logic       last;        // final byte caused by the current item
    logic       stream_end;  // final byte of the whole stream
  } byte_t;

  function automatic logic [7:0] run_hdr(input logic [CountW-1:0] len);
    run_hdr = 8'(RunBase) + len;
  endfunction

endpackage

FILE: hw/rtl/rle1_in_if.sv
`timescale 1ns / 1ps
// Input channel: one source byte per item with its end-of-stream flag.
interface rle1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

FILE: hw/rtl/rle1_out_if.sv
`timescale 1ns / 1ps
// Output channel: one packed word of up to four compressed bytes per item.
interface rle1_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] byte_count;
  logic       burst_end;
  logic       stream_end;

  modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                  output out_byte3, output byte_count, output burst_end,
                  output stream_end, input ready);
  modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                  input out_byte3, input byte_count, input burst_end,
                  input stream_end, output ready);
endinterface

FILE: hw/rtl/rle1_pack.sv
`timescale 1ns / 1ps
// Word packer: gathers compressed bytes into words of up to four and registers them.
module rle1_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_vld_i,
  input  rle1_pkg::byte_t    byte_i,
  output logic               byte_rdy_o,
  rle1_out_if.source         out_o
);

  logic [2:0][7:0] asm_q, asm_d;
  logic [1:0]      fill_q, fill_d;

  logic                                 out_vld_q, out_vld_d;
  logic [rle1_pkg::WordBytes-1:0][7:0]  word_q, word_d;
  logic [2:0]                           cnt_q, cnt_d;
  logic                                 burst_q, burst_d;
  logic                                 send_q, send_d;

  logic out_free;
  logic completes;
  logic adv;

  always_comb begin
    out_free   = !out_vld_q || out_o.ready;
    completes  = byte_i.last || (fill_q == 2'd3);
    byte_rdy_o = !completes || out_free;
    adv        = byte_vld_i && byte_rdy_o;

    asm_d     = asm_q;
    fill_d    = fill_q;
    word_d    = word_q;
    cnt_d     = cnt_q;
    burst_d   = burst_q;
    send_d    = send_q;
    out_vld_d = out_vld_q && !out_o.ready;

    if (adv) begin
      if (completes) begin
        // Close the word: gathered bytes, then this one, zeros beyond.
        word_d[0] = (fill_q == 2'd0) ? byte_i.data : asm_q[0];
        word_d[1] = (fill_q > 2'd1) ? asm_q[1] :
                    (fill_q == 2'd1) ? byte_i.data : 8'd0;
        word_d[2] = (fill_q > 2'd2) ? asm_q[2] :
                    (fill_q == 2'd2) ? byte_i.data : 8'd0;
        word_d[3] = (fill_q == 2'd3) ? byte_i.data : 8'd0;
        cnt_d     = {1'b0, fill_q} + 3'd1;
        burst_d   = byte_i.last;
        send_d    = byte_i.stream_end;
        out_vld_d = 1'b1;
        fill_d    = 2'd0;
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (fill_q == 2'(k)) begin
            asm_d[k] = byte_i.data;
          end
        end
        fill_d = fill_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= 2'd0;
      out_vld_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q   <= asm_d;
    word_q  <= word_d;
    cnt_q   <= cnt_d;
    burst_q <= burst_d;
    send_q  <= send_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.out_byte0  = word_q[0];
  assign out_o.out_byte1  = word_q[1];
  assign out_o.out_byte2  = word_q[2];
  assign out_o.out_byte3  = word_q[3];
  assign out_o.byte_count = cnt_q;
  assign out_o.burst_end  = burst_q;
  assign out_o.stream_end = send_q;

endmodule

FILE: hw/rtl/rle_type1_byte_encoder_top.sv
`timescale 1ns / 1ps
// Top level of the type 1 run-length encoder with literal store and word packer.
// Flow: an item that closes no group is taken and the next item follows at once; an item
//   that closes groups holds off input while its compressed bytes go out one byte a cycle
//   whenever the packer takes them; literal bytes come out of the single literal memory read port.
// Output: words leave through a registered stage.
// Reset: control state returns to an empty frame at once; the literal memory is not cleared.
module rle_type1_byte_encoder_top #(
  parameter int LITERAL_MAX = rle1_pkg::LiteralMax
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rle1_in_if.sink     in_i,
  rle1_out_if.source  out_o
);

  localparam int AW = (LITERAL_MAX > 2) ? $clog2(LITERAL_MAX) : 1;
  localparam int CW = rle1_pkg::CountW;

  // ---------------------------------------------------------------------------
  // Frame state: what is pending from the bytes seen so far
  // ---------------------------------------------------------------------------
  rle1_pkg::frame_mode_e mode_q, mode_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  // Run byte, the single pending byte, or the last literal byte in a literal.
  logic [7:0]            val_q, val_d;

  // Literal store: one write port at accept time, one registered read port.
  logic [7:0]    lit_mem_q [LITERAL_MAX];
  logic [7:0]    lit_rd_q;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // ---------------------------------------------------------------------------
  // Emission job: a literal (header plus stored bytes) then up to four tail bytes
  // ---------------------------------------------------------------------------
  rle1_pkg::emit_phase_e phase_q, phase_d;
  logic [CW-1:0]         lit_len_q, lit_len_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [3:0][7:0]       tail_q, tail_d;
  logic [2:0]            tail_cnt_q, tail_cnt_d;
  logic [1:0]            tidx_q, tidx_d;
  logic                  fin_q, fin_d;

  logic [CW-1:0]         job_lit;
  logic [3:0][7:0]       job_tail;
  logic [2:0]            job_tcnt;

  logic                  in_acc;
  logic                  byte_vld;
  logic                  byte_rdy;
  logic                  adv;
  rle1_pkg::byte_t       byte_s;

  assign in_i.ready = (phase_q == rle1_pkg::EP_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign adv        = byte_vld && byte_rdy;

  // ---------------------------------------------------------------------------
  // Accept: advance the frame and work out what this item emits
  // ---------------------------------------------------------------------------
  always_comb begin : accept_logic
    logic [CW-1:0] c1;
    logic [7:0]    b;

    b        = in_i.data_byte;
    c1       = cnt_q + CW'(1);
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    val_d    = val_q;
    job_lit  = '0;
    job_tail = '0;
    job_tcnt = 3'd0;
    wr_en    = in_acc;
    wr_addr  = '0;

    if (in_acc) begin
      unique case (mode_q)
        rle1_pkg::FM_EMPTY: begin
          // Park the byte at the head of the store in case a literal grows from it.
          mode_d  = rle1_pkg::FM_ONE;
          cnt_d   = CW'(1);
          val_d   = b;
          wr_addr = '0;
        end
        rle1_pkg::FM_ONE: begin
          wr_addr = AW'(1);
          if (b == val_q) begin
            mode_d = rle1_pkg::FM_RUN;
            cnt_d  = CW'(2);
          end else if (LITERAL_MAX <= 2) begin
            job_lit = CW'(2);
            mode_d  = rle1_pkg::FM_EMPTY;
            cnt_d   = '0;
          end else begin
            mode_d = rle1_pkg::FM_LIT;
            cnt_d  = CW'(2);
            val_d  = b;
          end
        end
        rle1_pkg::FM_RUN: begin
          wr_addr = '0;
          if (b == val_q) begin
            if (c1 >= CW'(rle1_pkg::RunMax)) begin
              // Run is full: send it and start afresh.
              job_tail[0] = rle1_pkg::run_hdr(c1);
              job_tail[1] = val_q;
              job_tcnt    = 3'd2;
              mode_d      = rle1_pkg::FM_EMPTY;
              cnt_d       = '0;
            end else begin
              cnt_d = c1;
            end
          end else begin
            // Run broken: send it, the new byte becomes the pending one.
            job_tail[0] = rle1_pkg::run_hdr(cnt_q);
            job_tail[1] = val_q;
            job_tcnt    = 3'd2;
            mode_d      = rle1_pkg::FM_ONE;
            cnt_d       = CW'(1);
            val_d       = b;
          end
        end
        rle1_pkg::FM_LIT: begin
          wr_addr = cnt_q[AW-1:0];
          if (b == val_q) begin
            // Repeated pair: close the literal before the pair, the pair opens a run.
            job_lit = cnt_q - CW'(1);
            mode_d  = rle1_pkg::FM_RUN;
            cnt_d   = CW'(2);
            val_d   = b;
          end else if ({1'b0, c1} >= (CW+1)'(LITERAL_MAX)) begin
            job_lit = c1;
            mode_d  = rle1_pkg::FM_EMPTY;
            cnt_d   = '0;
          end else begin
            cnt_d = c1;
            val_d = b;
          end
        end
        default: begin
          mode_d = rle1_pkg::FM_EMPTY;
        end
      endcase

      // End of stream: flush whatever is still pending after this byte.
      if (in_i.final_byte) begin
        unique case (mode_d)
          rle1_pkg::FM_ONE, rle1_pkg::FM_RUN: begin
            if (job_tcnt == 3'd0) begin
              job_tail[0] = (mode_d == rle1_pkg::FM_ONE) ? 8'd0 : rle1_pkg::run_hdr(cnt_d);
              job_tail[1] = val_d;
            end else begin
              job_tail[2] = (mode_d == rle1_pkg::FM_ONE) ? 8'd0 : rle1_pkg::run_hdr(cnt_d);
              job_tail[3] = val_d;
            end
            job_tcnt = job_tcnt + 3'd2;
          end
          rle1_pkg::FM_LIT: begin
            job_lit = cnt_d;
          end
          default: begin
          end
        endcase
        mode_d = rle1_pkg::FM_EMPTY;
        cnt_d  = '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Emission sequencer: while not stalled, one compressed byte a cycle towards the packer
  // ---------------------------------------------------------------------------
  always_comb begin : emit_logic
    logic body_last;
    logic tail_last;

    body_last = ({{(CW-AW){1'b0}}, idx_q} == (lit_len_q - CW'(1)));
    tail_last = ({1'b0, tidx_q} == (tail_cnt_q - 3'd1));

    phase_d    = phase_q;
    lit_len_d  = lit_len_q;
    idx_d      = idx_q;
    tail_d     = tail_q;
    tail_cnt_d = tail_cnt_q;
    tidx_d     = tidx_q;
    fin_d      = fin_q;
    byte_vld   = 1'b0;
    byte_s     = '0;

    unique case (phase_q)
      rle1_pkg::EP_IDLE: begin
        if (in_acc) begin
          lit_len_d  = job_lit;
          tail_d     = job_tail;
          tail_cnt_d = job_tcnt;
          fin_d      = in_i.final_byte;
          idx_d      = '0;
          tidx_d     = 2'd0;
          if (job_lit != '0) begin
            phase_d = rle1_pkg::EP_HDR;
          end else if (job_tcnt != 3'd0) begin
            phase_d = rle1_pkg::EP_TAIL;
          end
        end
      end
      rle1_pkg::EP_HDR: begin
        // Literal header; the read of the first stored byte is under way.
        byte_vld    = 1'b1;
        byte_s.data = lit_len_q - CW'(1);
        if (adv) begin
          phase_d = rle1_pkg::EP_BODY;
        end
      end
      rle1_pkg::EP_BODY: begin
        byte_vld    = 1'b1;
        byte_s.data = lit_rd_q;
        byte_s.last = body_last && (tail_cnt_q == 3'd0);
        if (adv) begin
          if (body_last) begin
            phase_d = (tail_cnt_q != 3'd0) ? rle1_pkg::EP_TAIL : rle1_pkg::EP_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      rle1_pkg::EP_TAIL: begin
        byte_vld    = 1'b1;
        byte_s.data = tail_q[tidx_q];
        byte_s.last = tail_last;
        if (adv) begin
          if (tail_last) begin
            phase_d = rle1_pkg::EP_IDLE;
          end else begin
            tidx_d = tidx_q + 2'd1;
          end
        end
      end
      default: begin
        phase_d = rle1_pkg::EP_IDLE;
      end
    endcase

    byte_s.stream_end = byte_s.last && fin_q;
  end

  // Read the entry that the sequencer points at next, so the registered data
  // always matches idx_q; hold re-reads the same entry.
  assign rd_addr = idx_d;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lit_mem_q[wr_addr] <= in_i.data_byte;
    end
    lit_rd_q <= lit_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= rle1_pkg::FM_EMPTY;
      cnt_q      <= '0;
      val_q      <= '0;
      phase_q    <= rle1_pkg::EP_IDLE;
      lit_len_q  <= '0;
      idx_q      <= '0;
      tail_cnt_q <= 3'd0;
      tidx_q     <= 2'd0;
      fin_q      <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      val_q      <= val_d;
      phase_q    <= phase_d;
      lit_len_q  <= lit_len_d;
      idx_q      <= idx_d;
      tail_cnt_q <= tail_cnt_d;
      tidx_q     <= tidx_d;
      fin_q      <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
  end

  // Pack bytes into words and hold each word in the output register.
  rle1_pack u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (byte_vld),
    .byte_i     (byte_s),
    .byte_rdy_o (byte_rdy),
    .out_o      (out_o)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the type 1 run-length byte encoder with a packed-word predictor.
module tb_top;

  // Stop the run here if the block hangs. A slow but correct run needs far fewer cycles.
  localparam int CycleLimit = 1_000_000;
  // Room after the last phase for the longest flush and the registered output stage.
  localparam int TailCycles = 200;
  localparam int ItemsPerPhase = 98;

  // One packed result word as it leaves the block.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] cnt;
    logic       burst;
    logic       strm;
  } word_t;

  // Encoder predictor and store of expected words.
  class rle_scoreboard;
    rle1_pkg::frame_mode_e mode;
    int          cnt;
    logic [7:0]  run_byte;
    logic [7:0]  lit[rle1_pkg::LiteralMax];
    logic [7:0]  coded[$];
    word_t       expected_words[$];
    int          errors;
    int          words_checked;
    int          bytes_noted;
    int          streams_closed;

    function new();
      mode = rle1_pkg::FM_EMPTY;
      cnt = 0;
      run_byte = '0;
      errors = 0;
      words_checked = 0;
      bytes_noted = 0;
      streams_closed = 0;
    endfunction

    function void put_run();
      coded.push_back(8'(rle1_pkg::RunBase + cnt));
      coded.push_back(run_byte);
    endfunction

    function void put_literal(int n);
      coded.push_back(8'(n - 1));
      for (int i = 0; i < n; i++) coded.push_back(lit[i]);
    endfunction

    function void go_empty();
      mode = rle1_pkg::FM_EMPTY;
      cnt = 0;
    endfunction

    function void take(logic [7:0] b);
      case (mode)
        rle1_pkg::FM_EMPTY: begin
          run_byte = b;
          mode = rle1_pkg::FM_ONE;
          cnt = 1;
        end
        rle1_pkg::FM_ONE: begin
          if (b == run_byte) begin
            mode = rle1_pkg::FM_RUN;
            cnt = 2;
          end else begin
            lit[0] = run_byte;
            lit[1] = b;
            mode = rle1_pkg::FM_LIT;
            cnt = 2;
          end
        end
        rle1_pkg::FM_RUN: begin
          if (b == run_byte) begin
            cnt++;
            if (cnt >= rle1_pkg::RunMax) begin
              put_run();
              go_empty();
            end
          end else begin
            put_run();
            run_byte = b;
            mode = rle1_pkg::FM_ONE;
            cnt = 1;
          end
        end
        default: begin
          lit[cnt] = b;
          cnt++;
          // A repeated pair closes the group in front of it and opens a run.
          if (lit[cnt-2] == b) begin
            put_literal(cnt - 2);
            run_byte = b;
            mode = rle1_pkg::FM_RUN;
            cnt = 2;
          end else if (cnt >= rle1_pkg::LiteralMax) begin
            put_literal(cnt);
            go_empty();
          end
        end
      endcase
    endfunction

    function void flush();
      case (mode)
        rle1_pkg::FM_ONE: begin
          coded.push_back(8'h00);
          coded.push_back(run_byte);
        end
        rle1_pkg::FM_RUN: put_run();
        rle1_pkg::FM_LIT: put_literal(cnt);
        default: ;
      endcase
      go_empty();
    endfunction

    // Encode one accepted source byte and queue the words it causes.
    function void note_byte(logic [7:0] b, logic fin);
      int         n;
      int         nw;
      word_t      w;
      logic [7:0] bt[4];
      bytes_noted++;
      take(b);
      if (fin) begin
        flush();
        streams_closed++;
      end
      n = coded.size();
      nw = (n + 3) / 4;
      for (int k = 0; k < nw; k++) begin
        for (int j = 0; j < 4; j++) bt[j] = (4*k + j < n) ? coded[4*k + j] : 8'h00;
        w.b0 = bt[0];
        w.b1 = bt[1];
        w.b2 = bt[2];
        w.b3 = bt[3];
        w.cnt = 3'((n - 4*k > 4) ? 4 : n - 4*k);
        w.burst = (k == nw - 1);
        w.strm = fin && (k == nw - 1);
        expected_words.push_back(w);
      end
      coded.delete();
    endfunction

    function void compare_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(word_t got);
      word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("byte_count mismatch: expected no word, actual %0d", got.cnt);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      words_checked++;
      compare_field("out_byte0", exp_w.b0, got.b0);
      compare_field("out_byte1", exp_w.b1, got.b1);
      compare_field("out_byte2", exp_w.b2, got.b2);
      compare_field("out_byte3", exp_w.b3, got.b3);
      compare_field("byte_count", exp_w.cnt, got.cnt);
      compare_field("burst_end", exp_w.burst, got.burst);
      compare_field("stream_end", exp_w.strm, got.strm);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rle1_in_if  in_if ();
  rle1_out_if out_if ();

  rle_type1_byte_encoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rle_scoreboard sb = new();

  int         cycle_count = 0;
  int         items_sent = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  logic [7:0] src_q[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort on a hang.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Note accepted items and check accepted words in one process, so that the
  // order of the two within an edge is fixed.
  always @(posedge clk_i) begin : monitor_blk
    word_t got;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.data_byte, in_if.final_byte);
      if (out_if.valid && out_if.ready) begin
        got.b0 = out_if.out_byte0;
        got.b1 = out_if.out_byte1;
        got.b2 = out_if.out_byte2;
        got.b3 = out_if.out_byte3;
        got.cnt = out_if.byte_count;
        got.burst = out_if.burst_end;
        got.strm = out_if.stream_end;
        sb.check_word(got);
      end
    end
  end

  // Stall the receiver at random according to the current phase.
  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Present one source byte, idling first at random, and hold it until taken.
  task automatic send_item(input logic [7:0] b, input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data_byte = b;
    in_if.final_byte = fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected word has come back.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly short lengths, now and then the limits either side.
  function automatic int pick_len(int top);
    if ($urandom_range(7) == 0) return $urandom_range(top + 1, top - 1);
    return $urandom_range(6, 1);
  endfunction

  function automatic void add_run(int len);
    logic [7:0] v;
    v = 8'($urandom);
    repeat (len) src_q.push_back(v);
  endfunction

  // Append bytes with no two neighbours equal.
  function automatic void add_literal(int len);
    logic [7:0] v;
    repeat (len) begin
      v = 8'($urandom);
      if (src_q.size() != 0 && v == src_q[$]) v = ~v;
      src_q.push_back(v);
    end
  endfunction

  function automatic void add_segment();
    logic [7:0] a;
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2: add_run(pick_len(rle1_pkg::RunMax));
      3, 4, 5: add_literal(pick_len(rle1_pkg::LiteralMax));
      6: begin
        // Group filled to the limit, then its last byte again: start afresh.
        add_literal(rle1_pkg::LiteralMax);
        src_q.push_back(src_q[$]);
      end
      7: begin
        // Repeated pair landing on the last slot of a full group.
        add_literal(rle1_pkg::LiteralMax - 1);
        src_q.push_back(src_q[$]);
      end
      8: add_run(rle1_pkg::RunMax + 1);
      default: begin
        // Noise from a two-value alphabet: pairs and broken groups.
        a = 8'($urandom);
        b = 8'($urandom);
        repeat ($urandom_range(6, 1)) src_q.push_back($urandom_range(1) ? a : b);
      end
    endcase
  endfunction

  // Build one stream of a few segments, cut to the budget, and send it with
  // the final flag on its last byte.
  task automatic send_stream(input int budget);
    src_q.delete();
    repeat ($urandom_range(4, 1)) add_segment();
    while (src_q.size() > budget) void'(src_q.pop_back());
    foreach (src_q[i]) send_item(src_q[i], i == src_q.size() - 1);
  endtask

  task automatic send_directed(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(bytes[i], i == bytes.size() - 1);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int target;
    idle_tab = '{0, 74, 0, 19};
    stall_tab = '{0, 0, 74, 19};
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.final_byte = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single leftover byte, shortest run, short literal, literal
    // broken by a pair, run followed by a single, extremes of the byte.
    send_directed('{8'h00});
    send_directed('{8'hFF, 8'hFF});
    send_directed('{8'h12, 8'h34, 8'h56});
    send_directed('{8'hA5, 8'h5A, 8'h5A, 8'h5A, 8'h00});
    send_directed('{8'hFE, 8'h01, 8'h02, 8'h02});
    send_directed('{8'h33, 8'h33, 8'h44});
    drain();

    // Random streams over the idling phases; drain between phases.
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = idle_tab[p];
      sink_stall_pct = stall_tab[p];
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) send_stream(target - items_sent);
      drain();
    end

    src_idle_pct = 0;
    sink_stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d source bytes in %0d streams; checked %0d packed words.",
             sb.bytes_noted, sb.streams_closed, sb.words_checked);
    $display("Phases: no idling, sender idle, receiver stalling, both; %0d mismatches.",
             sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
